// File: rtl/core/pfa_pkg.sv
`default_nettype none

package pfa_pkg;

    // Directory geometry, fixed by the 4 MB page format
    localparam int ENTRIES_PER_DIR = 1024;
    localparam int IDX_W           = 10;
    localparam int PDE_SHIFT       = 22;
    localparam logic [IDX_W-1:0] KERNEL_ENTRY = 10'h300;

    // Bitmap is scanned one word per cycle
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;

    // Stream payload widths (whole bytes)
    localparam int IN_W  = 48;
    localparam int OUT_W = 16;

    // Command codes
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_CHECK = 2'd2;

    // Bitmap update request from the sequencer
    typedef struct packed {
        logic set;
        logic clr;
    } map_op_t;

endpackage

`default_nettype wire

// File: rtl/core/pfa_dir_mem.sv
`default_nettype none

// Page directory entry store: {present, frame} per entry,
// one write and one registered read per cycle.
module pfa_dir_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int FW    = 5
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic          wr_present,
    input  wire logic [FW-1:0] wr_frame,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic               rd_present,
    output logic [FW-1:0]      rd_frame
);

    logic [FW:0] mem [DEPTH];
    logic [FW:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_present, wr_frame};
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_present = rd_data_reg[FW];
    assign rd_frame   = rd_data_reg[FW-1:0];

endmodule

`default_nettype wire

// File: rtl/core/pfa_bitmap.sv
`default_nettype none

// Frame-in-use bitmap held as 32-bit words. One word is selected per
// cycle; the lowest-free search runs over that word only.
module pfa_bitmap #(
    parameter int FRAME_COUNT = 32,
    parameter int WORDS       = 1,
    parameter int WW          = 1
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [WW-1:0]             word_sel,
    input  wire logic [pfa_pkg::BIT_W-1:0] bit_sel,
    input  wire pfa_pkg::map_op_t          op,
    output logic                           free_any,
    output logic [pfa_pkg::BIT_W-1:0]      free_bit,
    output logic                           bit_used
);

    logic [pfa_pkg::WORD_BITS-1:0] words_reg [WORDS];
    logic [pfa_pkg::WORD_BITS-1:0] cur_word;
    logic [pfa_pkg::WORD_BITS-1:0] free_mask;

    // Reset image: frame zero and padding past the last frame read as used
    function automatic logic [pfa_pkg::WORD_BITS-1:0] word_init(input int w);
        logic [pfa_pkg::WORD_BITS-1:0] v;
        int f;
        v = '0;
        for (int b = 0; b < pfa_pkg::WORD_BITS; b++)
        begin
            f = w * pfa_pkg::WORD_BITS + b;
            v[b] = (f == 0) || (f >= FRAME_COUNT);
        end
        return v;
    endfunction

    // Lowest set bit by halving: five dependent steps
    function automatic logic [pfa_pkg::BIT_W-1:0] low_one(
        input logic [pfa_pkg::WORD_BITS-1:0] v
    );
        logic [pfa_pkg::WORD_BITS-1:0] x;
        logic [pfa_pkg::BIT_W-1:0] pos;
        x = v;
        pos = '0;
        for (int k = pfa_pkg::BIT_W - 1; k >= 0; k--)
        begin
            if ((x & ((32'd1 << (1 << k)) - 32'd1)) == 32'd0)
            begin
                pos[k] = 1'b1;
                x = x >> (1 << k);
            end
        end
        return pos;
    endfunction

    // Word read and search
    assign cur_word  = words_reg[word_sel];
    assign free_mask = ~cur_word;
    assign free_any  = |free_mask;
    assign free_bit  = low_one(free_mask);
    assign bit_used  = cur_word[bit_sel];

    // Bit set on allocate, clear on release
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < WORDS; w++)
            begin
                words_reg[w] <= word_init(w);
            end
        end
        else if (op.set)
        begin
            words_reg[word_sel][free_bit] <= 1'b1;
        end
        else if (op.clr)
        begin
            words_reg[word_sel][bit_sel] <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/page_frame_allocator_core.sv
`default_nettype none

// Channel  Dir  Handshake           Payload
// s_*      in   s_tvalid/s_tready   s_tdata: cmd, dir_select, virt_addr, amount
// m_*      out  m_tvalid/m_tready   m_tdata: ok, frame_number, free_frames_now, flush_tlb
//
// Check and free pass from the transfer through the lookup and finish states
// to the result register; allocate also scans bitmap words in between, none
// when it fails at lookup, else 1..ceil(FRAME_COUNT/32) words.
// One item is in flight; s_tready is high only while the sequencer idles.
// After reset a clearing pass writes all DIRECTORY_COUNT*1024 directory entries,
// one entry a cycle, before the first input transfer.
// The result register lets a new item enter while the last result stalls.
module page_frame_allocator_core #(
    parameter int FRAME_COUNT     = 32,
    parameter int DIRECTORY_COUNT = 4
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // [1:0] cmd, [3:2] dir_select, [35:4] virt_addr, [41:36] amount
    input  wire logic [pfa_pkg::IN_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // [0] ok, [5:1] frame_number, [11:6] free_frames_now, [12] flush_tlb
    output logic [pfa_pkg::OUT_W-1:0]      m_tdata
);

    localparam int DEPTH = DIRECTORY_COUNT * pfa_pkg::ENTRIES_PER_DIR;
    localparam int AW    = $clog2(DEPTH);
    localparam int CLRW  = AW + 1;
    localparam int FW    = $clog2(FRAME_COUNT);
    localparam int WORDS = (FRAME_COUNT + pfa_pkg::WORD_BITS - 1) / pfa_pkg::WORD_BITS;
    localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CNTW  = $clog2(FRAME_COUNT + 1);
    localparam int CMPW  = (CNTW > 6) ? CNTW : 6;
    localparam int XW    = WW + pfa_pkg::BIT_W;

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_LOOKUP = 5'b00100,
        S_SCAN   = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t                   state_reg, state_next;
    logic [CLRW-1:0]          clr_reg, clr_next;
    logic [1:0]               cmd_reg, cmd_next;
    logic                     dir_ok_reg, dir_ok_next;
    logic [AW-1:0]            addr_reg, addr_next;
    logic [5:0]               amount_reg, amount_next;
    logic [WW-1:0]            word_reg, word_next;
    logic [CNTW-1:0]          count_reg, count_next;
    logic                     res_ok_reg, res_ok_next;
    logic [FW-1:0]            res_frame_reg, res_frame_next;
    logic                     res_flush_reg, res_flush_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [pfa_pkg::OUT_W-1:0] m_tdata_reg, m_tdata_next;

    // Input field split
    logic [1:0]                 in_cmd;
    logic [1:0]                 in_dir;
    logic [31:0]                in_va;
    logic [5:0]                 in_amount;
    logic [pfa_pkg::IDX_W-1:0]  in_idx;
    logic [AW+1:0]              in_addr_wide;
    logic                       in_dir_ok;

    // Store and bitmap hookup
    logic                       accept;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic                       wr_present;
    logic [FW-1:0]              wr_frame;
    logic                       rd_present;
    logic [FW-1:0]              rd_frame;
    logic [XW-1:0]              rd_frame_ext;
    logic [XW-1:0]              found_ext;
    logic [FW-1:0]              found_frame;
    logic [WW-1:0]              map_word;
    logic [pfa_pkg::BIT_W-1:0]  map_bit;
    pfa_pkg::map_op_t           map_op;
    logic                       free_any;
    logic [pfa_pkg::BIT_W-1:0]  free_bit;
    logic                       bit_used;

    assign in_cmd       = s_tdata[1:0];
    assign in_dir       = s_tdata[3:2];
    assign in_va        = s_tdata[35:4];
    assign in_amount    = s_tdata[41:36];
    assign in_idx       = in_va[pfa_pkg::PDE_SHIFT +: pfa_pkg::IDX_W];
    assign in_addr_wide = (AW + 2)'({in_dir, in_idx});
    assign in_dir_ok    = (int'(in_dir) < DIRECTORY_COUNT);

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Frame number split into bitmap word and bit
    assign rd_frame_ext = XW'(rd_frame);
    assign found_ext    = {word_reg, free_bit};
    assign found_frame  = found_ext[FW-1:0];
    assign map_word     = (state_reg == S_SCAN) ? word_reg : rd_frame_ext[XW-1:pfa_pkg::BIT_W];
    assign map_bit      = rd_frame_ext[pfa_pkg::BIT_W-1:0];

    pfa_dir_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .FW    (FW)
    ) u_dir_mem (
        .clk        (clk),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_present (wr_present),
        .wr_frame   (wr_frame),
        .rd_en      (accept),
        .rd_addr    (in_addr_wide[AW-1:0]),
        .rd_present (rd_present),
        .rd_frame   (rd_frame)
    );

    pfa_bitmap #(
        .FRAME_COUNT (FRAME_COUNT),
        .WORDS       (WORDS),
        .WW          (WW)
    ) u_bitmap (
        .clk      (clk),
        .rst_n    (rst_n),
        .word_sel (map_word),
        .bit_sel  (map_bit),
        .op       (map_op),
        .free_any (free_any),
        .free_bit (free_bit),
        .bit_used (bit_used)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cmd_next       = cmd_reg;
        dir_ok_next    = dir_ok_reg;
        addr_next      = addr_reg;
        amount_next    = amount_reg;
        word_next      = word_reg;
        count_next     = count_reg;
        res_ok_next    = res_ok_reg;
        res_frame_next = res_frame_reg;
        res_flush_next = res_flush_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        wr_en          = 1'b0;
        wr_addr        = addr_reg;
        wr_present     = 1'b0;
        wr_frame       = rd_frame;
        map_op         = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en      = 1'b1;
                wr_addr    = clr_reg[AW-1:0];
                wr_present = (clr_reg[pfa_pkg::IDX_W-1:0] == pfa_pkg::KERNEL_ENTRY);
                wr_frame   = '0;
                clr_next   = clr_reg + CLRW'(1);
                if (clr_reg == CLRW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next    = in_cmd;
                    dir_ok_next = in_dir_ok;
                    addr_next   = in_addr_wide[AW-1:0];
                    amount_next = in_amount;
                    state_next  = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                res_ok_next    = 1'b0;
                res_frame_next = '0;
                res_flush_next = 1'b0;
                state_next     = S_FINISH;
                priority if (cmd_reg == pfa_pkg::CMD_CHECK)
                begin
                    res_ok_next = (CMPW'(amount_reg) <= CMPW'(count_reg));
                end
                else if (cmd_reg == pfa_pkg::CMD_ALLOC && dir_ok_reg)
                begin
                    if (!rd_present && count_reg != '0)
                    begin
                        word_next  = '0;
                        state_next = S_SCAN;
                    end
                end
                else if (cmd_reg == pfa_pkg::CMD_FREE && dir_ok_reg && rd_present)
                begin
                    // Entry cleared; frame released only if still marked used
                    wr_en          = 1'b1;
                    wr_present     = 1'b0;
                    res_ok_next    = 1'b1;
                    res_frame_next = rd_frame;
                    res_flush_next = 1'b1;
                    if (bit_used)
                    begin
                        map_op.clr = 1'b1;
                        count_next = count_reg + CNTW'(1);
                    end
                end
                else
                begin
                    res_ok_next = 1'b0;
                end
            end
            S_SCAN:
            begin
                if (free_any)
                begin
                    map_op.set     = 1'b1;
                    wr_en          = 1'b1;
                    wr_present     = 1'b1;
                    wr_frame       = found_frame;
                    res_ok_next    = 1'b1;
                    res_frame_next = found_frame;
                    res_flush_next = 1'b1;
                    count_next     = count_reg - CNTW'(1);
                    state_next     = S_FINISH;
                end
                else if (word_reg == WW'(WORDS - 1))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    word_next = word_reg + WW'(1);
                end
            end
            S_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, res_flush_reg, 6'(count_reg),
                                     5'(res_frame_reg), res_ok_reg};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            count_reg    <= CNTW'(FRAME_COUNT - 1);
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        dir_ok_reg    <= dir_ok_next;
        addr_reg      <= addr_next;
        amount_reg    <= amount_next;
        word_reg      <= word_next;
        res_ok_reg    <= res_ok_next;
        res_frame_reg <= res_frame_next;
        res_flush_reg <= res_flush_next;
        m_tdata_reg   <= m_tdata_next;
    end

`ifndef SYNTH
    // Free count never exceeds the number of frames
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(FRAME_COUNT))
        else $error("free frame count out of range");

    // A flush request only comes with a successful result
    a_flush_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[12] |-> m_tdata[0])
        else $error("flush_tlb set on a failed result");

    // An accepted item goes straight to the directory lookup
    a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == S_LOOKUP)
        else $error("accepted item did not enter lookup");

    // The bitmap is never set and cleared in the same cycle
    a_map_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(map_op.set && map_op.clr))
        else $error("conflicting bitmap update");
`endif

endmodule

`default_nettype wire
